// ----- rtl/ack_wait_retransmit_table_macros.svh -----
// Assertion macros shared by the table's modules.
// Depends on nothing; each macro is one concurrent assertion.
`ifndef ACK_WAIT_RETRANSMIT_TABLE_MACROS_SVH
`define ACK_WAIT_RETRANSMIT_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AWRT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Condition that must hold on every clock edge outside reset.
`define AWRT_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`endif

// ----- rtl/awrt_pkg.sv -----
// Shared types and constants of the acknowledgment wait table.
// Depends on nothing.
package awrt_pkg;

  localparam int unsigned SLOTS_DEFAULT = 10;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_CANCEL = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  localparam logic CFG_RESEND_PERIOD = 1'b0;
  localparam logic CFG_ACK_CODE = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_RESENT = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] msg_start;
    logic [7:0] msg_src;
    logic [7:0] msg_dest;
    logic [7:0] msg_cmd;
    logic [7:0] msg_data0;
    logic [7:0] msg_data1;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_start;
    logic [7:0] out_src;
    logic [7:0] out_dest;
    logic [7:0] out_cmd;
    logic [7:0] out_data0;
    logic [7:0] out_data1;
    logic [3:0] pending_count;
    logic       overload;
    logic       available;
    logic       last;
  } out_item_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic       sweep;
    in_item_t   item;
  } cmd_t;

endpackage

// ----- rtl/awrt_front.sv -----
// Front part: accepts input items, keeps the tick counter and marks sweeps.
// Depends on awrt_pkg.
module awrt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  awrt_pkg::in_item_t in_item,
  input  logic [15:0]        resend_period,
  output logic               cmd_valid,
  input  logic               cmd_stall,
  output awrt_pkg::cmd_t     cmd
);
  import awrt_pkg::*;

  logic [15:0] elapsed_ticks;
  logic [15:0] ticks_inc;
  logic        take;
  logic        sweep;

  assign in_stall = cmd_valid && cmd_stall;
  assign take = in_valid && !in_stall;
  assign ticks_inc = (elapsed_ticks == 16'hFFFF) ? elapsed_ticks : elapsed_ticks + 16'd1;
  assign sweep = (resend_period != 16'd0) && (ticks_inc >= resend_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ticks <= '0;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        cmd_valid <= 1'b0;
      end
      if (take) begin
        cmd_valid <= 1'b1;
        cmd.item <= in_item;
        cmd.sweep <= (in_item.op == OP_TICK) && sweep;
        if (in_item.op == OP_TICK) begin
          elapsed_ticks <= sweep ? 16'd0 : ticks_inc;
        end
      end
    end
  end

  `include "ack_wait_retransmit_table_macros.svh"
  `AWRT_ASSERT_IMP(a_stall_holds, clk, rst, cmd_valid && cmd_stall, ##1 cmd_valid)
  `AWRT_ASSERT_IMP(a_sweep_tick, clk, rst, cmd_valid && cmd.sweep, cmd.item.op == OP_TICK)
  `AWRT_ASSERT_IMP(a_sweep_nonzero, clk, rst, cmd_valid && cmd.sweep, resend_period != 16'd0)
endmodule

// ----- rtl/awrt_back.sv -----
// Back part: holds the slot table, applies commands and emits results.
// Depends on awrt_pkg.
module awrt_back #(
  parameter int unsigned SLOTS = awrt_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  awrt_pkg::cmd_t      cmd,
  input  logic [7:0]          ack_code,
  output logic                out_valid,
  input  logic                out_stall,
  output awrt_pkg::out_item_t out_item
);
  import awrt_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_STATUS} state_t;

  state_t          state;
  logic [SLOTS-1:0] slot_valid;
  logic [47:0]     slot_message [SLOTS];
  logic [CW-1:0]   occupied_count;
  logic            overload_flag;
  logic            available_flag;
  logic [IW-1:0]   sweep_idx;

  logic [SLOTS-1:0] full_hit;
  logic [SLOTS-1:0] head_hit;
  logic [IW-1:0]   free_idx, full_idx, head_idx;
  logic            free_any, full_any, head_any;
  logic [47:0]     m;
  logic            out_free;
  logic            take;
  logic [47:0]     sm;

  assign m = {cmd.item.msg_start, cmd.item.msg_src, cmd.item.msg_dest,
              cmd.item.msg_cmd, cmd.item.msg_data0, cmd.item.msg_data1};
  assign out_free = !out_valid || !out_stall;
  assign cmd_stall = (state != S_IDLE) || !out_free;
  assign take = cmd_valid && !cmd_stall;
  assign sm = slot_message[sweep_idx];

  always_comb begin
    free_idx = '0; full_idx = '0; head_idx = '0;
    free_any = 1'b0; full_any = 1'b0; head_any = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      full_hit[i] = slot_valid[i] && (slot_message[i] == m);
      head_hit[i] = slot_valid[i] && (slot_message[i][47:16] == m[47:16]);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_any = 1'b1; free_idx = IW'(i);
      end
      if (full_hit[i]) begin
        full_any = 1'b1; full_idx = IW'(i);
      end
      if (head_hit[i]) begin
        head_any = 1'b1; head_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.item.op == OP_ADD && !full_any && free_any) begin
      slot_message[free_idx] <= m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      occupied_count <= '0;
      overload_flag <= 1'b0;
      available_flag <= 1'b0;
      sweep_idx <= '0;
      out_valid <= 1'b0;
      out_item.kind <= KIND_STATUS;
      out_item.last <= 1'b0;
      out_item.pending_count <= '0;
      out_item.overload <= 1'b0;
      out_item.available <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            priority if (cmd.item.op == OP_ADD) begin
              if (!full_any) begin
                if (free_any) begin
                  slot_valid[free_idx] <= 1'b1;
                  occupied_count <= occupied_count + CW'(1);
                  overload_flag <= 1'b0;
                  available_flag <= 1'b1;
                end else begin
                  overload_flag <= 1'b1;
                end
              end
              state <= S_STATUS;
            end else if (cmd.item.op == OP_CANCEL) begin
              if (head_any) begin
                slot_valid[head_idx] <= 1'b0;
                occupied_count <= occupied_count - CW'(1);
              end
              state <= S_STATUS;
            end else if (cmd.item.op == OP_CLEAR) begin
              if (full_any) begin
                slot_valid[full_idx] <= 1'b0;
                occupied_count <= occupied_count - CW'(1);
              end
              state <= S_STATUS;
            end else if (cmd.item.op == OP_CLEAR_ALL) begin
              slot_valid <= '0;
              occupied_count <= '0;
              overload_flag <= 1'b0;
              available_flag <= 1'b0;
              state <= S_STATUS;
            end else if (cmd.sweep) begin
              sweep_idx <= '0;
              state <= S_SWEEP;
            end else begin
              state <= S_STATUS;
            end
          end
        end
        S_SWEEP: begin
          if (out_free) begin
            if (slot_valid[sweep_idx]) begin
              out_valid <= 1'b1;
              out_item.kind <= KIND_RESENT;
              out_item.out_start <= ack_code;
              {out_item.out_src, out_item.out_dest, out_item.out_cmd,
               out_item.out_data0, out_item.out_data1} <= sm[39:0];
              out_item.last <= 1'b0;
              out_item.pending_count <= 4'(occupied_count);
              out_item.overload <= overload_flag;
              out_item.available <= available_flag;
            end
            if (sweep_idx == IW'(SLOTS - 1)) begin
              state <= S_STATUS;
            end else begin
              sweep_idx <= sweep_idx + IW'(1);
            end
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_item.kind <= KIND_STATUS;
            out_item.last <= 1'b1;
            out_item.pending_count <= 4'(occupied_count);
            out_item.overload <= overload_flag;
            out_item.available <= available_flag;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "ack_wait_retransmit_table_macros.svh"
  `AWRT_ASSERT_ALWAYS(a_count, clk, rst, occupied_count == CW'($countones(slot_valid)))
  `AWRT_ASSERT_IMP(a_last_status, clk, rst, out_valid, out_item.last == (out_item.kind == KIND_STATUS))
  `AWRT_ASSERT_IMP(a_out_hold, clk, rst, out_valid && out_stall, ##1 out_valid)
endmodule

// ----- rtl/ack_wait_retransmit_table.sv -----
// Top level of the acknowledgment wait table: config registers, front, back.
// Depends on awrt_pkg, awrt_front and awrt_back.
//
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/stall | in_item (in_item_t)
//  out     | output    | out_valid/stall| out_item (out_item_t)
//  cfg     | input     | cfg_valid/ready| cfg_index, cfg_data
//
// Add, cancel, clear, clear-all and plain ticks pass the front register, then
// the back part, whose slot compare is parallel, then its status state.
// A resend sweep walks the table one slot a cycle while the output does not stall.
// Reset is synchronous; the table needs no clearing pass.
// A stalled output holds the back part, and the front part behind it.
module ack_wait_retransmit_table #(
  parameter int unsigned SLOTS = awrt_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  awrt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output awrt_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import awrt_pkg::*;

  logic [15:0] resend_period;
  logic [7:0]  ack_code;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_t        cmd;
  out_item_t   back_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      resend_period <= '0;
      ack_code <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index[0])
        CFG_RESEND_PERIOD: resend_period <= cfg_data;
        CFG_ACK_CODE:      ack_code <= cfg_data[7:0];
        default:           ;
      endcase
    end
  end

  awrt_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item, .resend_period,
    .cmd_valid, .cmd_stall, .cmd
  );

  awrt_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd, .ack_code,
    .out_valid, .out_stall, .out_item(back_item)
  );

  // Status items show zero message bytes.
  always_comb begin
    out_item = back_item;
    if (back_item.kind == KIND_STATUS) begin
      out_item.out_start = '0;
      out_item.out_src = '0;
      out_item.out_dest = '0;
      out_item.out_cmd = '0;
      out_item.out_data0 = '0;
      out_item.out_data1 = '0;
    end
  end
endmodule
